/* rtl/aecd_pkg.sv */
// Package for the alternating-end character deque.
// Holds the sizes, operation and status codes and the transaction and cell command types.
// No dependencies.
`timescale 1ns / 1ps

package aecd_pkg;

   // Number of cells in the chain, which is also the largest capacity.
   localparam int DEPTH  = 64;
   localparam int CHAR_W = 8;
   localparam int CAP_W  = 7;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CAP_W > CNT_W) ? CAP_W : CNT_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic [1:0] {
      OP_RESTART   = 2'd0,
      OP_INSERT    = 2'd1,
      OP_POP_FRONT = 2'd2,
      OP_POP_BACK  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_FULL     = 3'd1,
      ST_MATCH    = 3'd2,
      ST_REJECTED = 3'd3,
      ST_POPPED   = 3'd4,
      ST_EMPTY    = 3'd5,
      ST_CLEARED  = 3'd6
   } status_type;

   typedef struct packed {
      op_type              operation;
      logic [CHAR_W-1:0]   char_in;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [CHAR_W-1:0]   char_out;
      logic [CAP_W-1:0]    fill_count;
   } rsp_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      logic                clear;
      logic                push_front;
      logic                push_back;
      logic                pop_front;
      logic                pop_back;
      logic [CHAR_W-1:0]   push_char;
   } cell_cmd_type;

endpackage

/* rtl/alternating_end_char_deque_core.sv */
// Top level of the alternating-end character deque.
// Depends on aecd_pkg and instantiates a row of aecd_cell.
`timescale 1ns / 1ps

// A transaction is accepted and executed when req_valid is high and req_stall low,
// and in the next cycle the registered copy of the back-end character is refreshed from the
// cell row, during which req_stall is high. The result is held in an output register
// until it is taken; a new transaction is accepted once the result register is free
// or is being emptied. The capacity register may be written at any cycle while idle
// and takes effect at the next insert. No clearing pass is needed after reset.
module alternating_end_char_deque_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  aecd_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output aecd_pkg::rsp_type          rsp_data,
   input  logic                       csr_wr_en,
   input  logic [aecd_pkg::CAP_W-1:0] csr_wr_data
);

   localparam int D = aecd_pkg::DEPTH;

   logic [aecd_pkg::CAP_W-1:0]  cap_ff;
   logic [aecd_pkg::CNT_W-1:0]  count_ff;
   logic [aecd_pkg::CNT_W-1:0]  count_in;
   logic                        side_ff;
   logic                        side_in;
   logic                        ended_ff;
   logic                        ended_in;
   logic                        settle_ff;
   logic [aecd_pkg::CHAR_W-1:0] back_ff;
   logic [aecd_pkg::CHAR_W-1:0] back_in;
   logic                        rsp_valid_ff;
   aecd_pkg::rsp_type           rsp_ff;
   aecd_pkg::rsp_type           rsp_in;
   aecd_pkg::cell_cmd_type      cmd;

   logic [D-1:0]                occ_w;
   logic [aecd_pkg::CHAR_W-1:0] data_w [D];

   logic                        accept;
   logic [aecd_pkg::CMP_W-1:0]  cap_eff;
   logic [aecd_pkg::CMP_W-1:0]  cnt_ext;
   logic [aecd_pkg::CMP_W-1:0]  cnt_inc_ext;
   logic [aecd_pkg::CHAR_W-1:0] opp_char;

   assign req_stall = settle_ff || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign cap_eff = (aecd_pkg::CMP_W'(cap_ff) > aecd_pkg::CMP_W'(D))
                    ? aecd_pkg::CMP_W'(D) : aecd_pkg::CMP_W'(cap_ff);
   assign cnt_ext     = aecd_pkg::CMP_W'(count_ff);
   assign cnt_inc_ext = cnt_ext + aecd_pkg::CMP_W'(1);
   assign opp_char    = side_ff ? data_w[0] : back_ff;

   // The back end is the last occupied cell; exactly one cell qualifies when the
   // deque is not empty, so an OR of the gated characters selects it.
   always_comb begin
      back_in = '0;
      for (int i = 0; i < D; i++) begin
         if (occ_w[i] && ((i == D - 1) || !occ_w[(i + 1) % D])) begin
            back_in = back_in | data_w[i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      side_in  = side_ff;
      ended_in = ended_ff;
      cmd      = '0;
      cmd.push_char = req_data.char_in;
      rsp_in.status     = aecd_pkg::ST_REJECTED;
      rsp_in.char_out   = '0;
      case (req_data.operation)
         aecd_pkg::OP_RESTART: begin
            count_in  = '0;
            side_in   = 1'b0;
            ended_in  = 1'b0;
            cmd.clear = 1'b1;
            rsp_in.status = aecd_pkg::ST_CLEARED;
         end
         aecd_pkg::OP_INSERT: begin
            if (ended_ff) begin
               rsp_in.status = aecd_pkg::ST_REJECTED;
            end else if (cnt_ext >= cap_eff) begin
               ended_in      = 1'b1;
               rsp_in.status = aecd_pkg::ST_REJECTED;
            end else if ((count_ff != '0) && (opp_char == req_data.char_in)) begin
               ended_in        = 1'b1;
               rsp_in.status   = aecd_pkg::ST_MATCH;
               rsp_in.char_out = opp_char;
            end else begin
               cmd.push_front = !side_ff;
               cmd.push_back  = side_ff;
               count_in       = count_ff + aecd_pkg::CNT_W'(1);
               side_in        = !side_ff;
               if (cnt_inc_ext >= cap_eff) begin
                  ended_in      = 1'b1;
                  rsp_in.status = aecd_pkg::ST_FULL;
               end else begin
                  rsp_in.status = aecd_pkg::ST_INSERTED;
               end
            end
         end
         aecd_pkg::OP_POP_FRONT: begin
            if (count_ff == '0) begin
               rsp_in.status = aecd_pkg::ST_EMPTY;
            end else begin
               cmd.pop_front   = 1'b1;
               count_in        = count_ff - aecd_pkg::CNT_W'(1);
               rsp_in.status   = aecd_pkg::ST_POPPED;
               rsp_in.char_out = data_w[0];
            end
         end
         aecd_pkg::OP_POP_BACK: begin
            if (count_ff == '0) begin
               rsp_in.status = aecd_pkg::ST_EMPTY;
            end else begin
               cmd.pop_back    = 1'b1;
               count_in        = count_ff - aecd_pkg::CNT_W'(1);
               rsp_in.status   = aecd_pkg::ST_POPPED;
               rsp_in.char_out = back_ff;
            end
         end
         default: begin
            rsp_in.status = aecd_pkg::ST_REJECTED;
         end
      endcase
      rsp_in.fill_count = aecd_pkg::CAP_W'(count_in);
      if (!accept) begin
         cmd      = '0;
         count_in = count_ff;
         side_in  = side_ff;
         ended_in = ended_ff;
      end
   end

   for (genvar g = 0; g < D; g++) begin : g_cell
      logic                        l_occ;
      logic [aecd_pkg::CHAR_W-1:0] l_data;
      logic                        r_occ;
      logic [aecd_pkg::CHAR_W-1:0] r_data;

      if (g == 0) begin : g_first
         assign l_occ  = 1'b1;
         assign l_data = cmd.push_char;
      end else begin : g_mid_l
         assign l_occ  = occ_w[g-1];
         assign l_data = data_w[g-1];
      end

      if (g == D - 1) begin : g_last
         assign r_occ  = 1'b0;
         assign r_data = '0;
      end else begin : g_mid_r
         assign r_occ  = occ_w[g+1];
         assign r_data = data_w[g+1];
      end

      aecd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_occ   (l_occ),
         .left_data  (l_data),
         .right_occ  (r_occ),
         .right_data (r_data),
         .occ_out    (occ_w[g]),
         .data_out   (data_w[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= aecd_pkg::CAP_RESET;
         count_ff     <= '0;
         side_ff      <= 1'b0;
         ended_ff     <= 1'b0;
         settle_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         count_ff  <= count_in;
         side_ff   <= side_in;
         ended_ff  <= ended_in;
         settle_ff <= accept;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      back_ff <= back_in;
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

/* rtl/aecd_cell.sv */
// One cell of the deque chain: an occupied flag and one character.
// Depends on aecd_pkg for the character width and the cell command type.
`timescale 1ns / 1ps

module aecd_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  aecd_pkg::cell_cmd_type      cmd,
   input  logic                        left_occ,
   input  logic [aecd_pkg::CHAR_W-1:0] left_data,
   input  logic                        right_occ,
   input  logic [aecd_pkg::CHAR_W-1:0] right_data,
   output logic                        occ_out,
   output logic [aecd_pkg::CHAR_W-1:0] data_out
);

   logic                        occ_ff;
   logic                        occ_in;
   logic [aecd_pkg::CHAR_W-1:0] data_ff;
   logic [aecd_pkg::CHAR_W-1:0] data_in;

   // Cells hold the contents in order, front in the first cell. A front push shifts
   // the row towards the back, a front pop towards the front; back operations only
   // touch the cell at the boundary of the occupied run.
   always_comb begin
      occ_in  = occ_ff;
      data_in = data_ff;
      if (cmd.clear) begin
         occ_in = 1'b0;
      end else if (cmd.push_front) begin
         occ_in  = left_occ;
         data_in = left_data;
      end else if (cmd.pop_front) begin
         occ_in  = right_occ;
         data_in = right_data;
      end else if (cmd.push_back && !occ_ff && left_occ) begin
         occ_in  = 1'b1;
         data_in = cmd.push_char;
      end else if (cmd.pop_back && occ_ff && !right_occ) begin
         occ_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign occ_out  = occ_ff;
   assign data_out = data_ff;

endmodule

/* rtl/aecd_checker.sv */
// Port-level checker for the alternating-end character deque, bound to the top level.
// Depends on aecd_pkg and alternating_end_char_deque_core.
`timescale 1ns / 1ps

module aecd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input aecd_pkg::req_type          req_data,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input aecd_pkg::rsp_type          rsp_data,
   input logic                       csr_wr_en,
   input logic [aecd_pkg::CAP_W-1:0] csr_wr_data
);

   logic req_accept;
   logic cfg_seen;

   assign req_accept = req_valid && !req_stall;
   assign cfg_seen   = csr_wr_en && (csr_wr_data != csr_wr_data + aecd_pkg::CAP_W'(1));

   // A waiting result stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // Every accepted transaction produces a result in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("no result after accepted transaction");

   // The cycle after an accepted transaction is spent refreshing the back end.
   a_settle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("transaction accepted during settle cycle");

   // A restart accepted while no capacity write is under way reports cleared with an empty deque.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_data.operation == aecd_pkg::OP_RESTART) && !cfg_seen |=>
      (rsp_data.status == aecd_pkg::ST_CLEARED) && (rsp_data.fill_count == '0) &&
      (rsp_data.char_out == '0))
      else $error("restart result wrong");

endmodule

bind alternating_end_char_deque_core aecd_checker u_aecd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_data    (req_data),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_data    (rsp_data),
   .csr_wr_en   (csr_wr_en),
   .csr_wr_data (csr_wr_data)
);

/* tb/alternating_end_char_deque_core_tb.sv */
// Testbench for alternating_end_char_deque_core: directed table, then random sessions.
// Checks typed rows against the table, the rest against a behavioural deque model. Depends on aecd_pkg and the core.
`timescale 1ns / 1ps

module alternating_end_char_deque_core_tb;
   import aecd_pkg::*;

   typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      logic [CAP_W-1:0] cap;
      op_type           op;
      logic [7:0]       ch;
      bit               typed;
      rsp_type          want;
   } dir_row_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   req_type          req_data    = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en   = 1'b0;
   logic [CAP_W-1:0] csr_wr_data = '0;

   // Model state of the deque.
   logic [7:0]       deque_store [DEPTH];
   logic [5:0]       front_idx      = '0;
   int               fill           = 0;
   bit               back_next      = 1'b0;
   bit               session_closed = 1'b0;
   logic [CAP_W-1:0] cap_reg        = CAP_RESET;

   rsp_type          pending_results [$];
   dir_row_type      directed_rows [$];
   int               errors       = 0;
   int               sent_items   = 0;
   int               burst_left   = 0;
   int               alpha_size   = 256;
   logic [7:0]       alpha_base   = '0;
   int               stall_cycle  = 0;
   int               stall_mode   = 0;

   alternating_end_char_deque_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // Works out the result of one transaction and advances the model state.
   function automatic rsp_type deque_apply(input req_type r);
      rsp_type    res;
      int         eff_cap;
      logic [7:0] far_char;
      eff_cap = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
      res.status   = ST_REJECTED;
      res.char_out = '0;
      far_char     = '0;
      case (r.operation)
         OP_RESTART: begin
            front_idx      = '0;
            fill           = 0;
            back_next      = 1'b0;
            session_closed = 1'b0;
            res.status     = ST_CLEARED;
         end
         OP_INSERT: begin
            if (session_closed) begin
               res.status = ST_REJECTED;
            end else if (fill >= eff_cap) begin
               session_closed = 1'b1;
            end else begin
               // The comparison is always against the end opposite the insert side.
               if (fill > 0) begin
                  far_char = back_next ? deque_store[front_idx]
                                       : deque_store[6'(front_idx + fill - 1)];
               end
               if (fill > 0 && far_char == r.char_in) begin
                  session_closed = 1'b1;
                  res.status     = ST_MATCH;
                  res.char_out   = far_char;
               end else begin
                  if (!back_next) begin
                     front_idx = front_idx - 6'd1;
                     deque_store[front_idx] = r.char_in;
                  end else begin
                     deque_store[6'(front_idx + fill)] = r.char_in;
                  end
                  fill++;
                  back_next = !back_next;
                  if (fill >= eff_cap) begin
                     session_closed = 1'b1;
                     res.status     = ST_FULL;
                  end else begin
                     res.status = ST_INSERTED;
                  end
               end
            end
         end
         default: begin
            if (fill == 0) begin
               res.status = ST_EMPTY;
            end else if (r.operation == OP_POP_FRONT) begin
               res.char_out = deque_store[front_idx];
               front_idx    = front_idx + 6'd1;
               fill--;
               res.status   = ST_POPPED;
            end else begin
               res.char_out = deque_store[6'(front_idx + fill - 1)];
               fill--;
               res.status   = ST_POPPED;
            end
         end
      endcase
      res.fill_count = CAP_W'(fill);
      return res;
   endfunction

   // Sends one transaction in the current burst and records its expected result.
   task automatic issue(input op_type op, input logic [7:0] ch, input bit typed,
                        input rsp_type typed_rsp);
      req_type r;
      rsp_type want;
      int      gap;
      r.operation = op;
      r.char_in   = ch;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      want = deque_apply(r);
      sent_items++;
      pending_results.push_back(typed ? typed_rsp : want);
   endtask

   // Holds the sender back until every outstanding result has been taken.
   task automatic drain;
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cap_reg = value;
   endtask

   function automatic void cfg_row(input logic [CAP_W-1:0] value);
      dir_row_type row;
      row = '{kind: ROW_CFG, cap: value, op: OP_RESTART, ch: '0, typed: 1'b0, want: '0};
      directed_rows.push_back(row);
   endfunction

   function automatic void item_row(input op_type op, input logic [7:0] ch, input bit typed,
                                    input status_type st, input logic [7:0] co,
                                    input int cnt);
      dir_row_type row;
      rsp_type     want;
      want.status     = st;
      want.char_out   = co;
      want.fill_count = CAP_W'(cnt);
      row = '{kind: ROW_ITEM, cap: '0, op: op, ch: ch, typed: typed, want: want};
      directed_rows.push_back(row);
   endfunction

   function automatic logic [7:0] pick_char;
      if (alpha_size >= 256) begin
         return 8'($urandom_range(0, 255));
      end
      return alpha_base + 8'($urandom_range(0, alpha_size - 1));
   endfunction

   // One session: capacity setting, usually a restart, inserts until the session ends, then read-out.
   task automatic run_session;
      int               pick;
      int               guard;
      int               n_pops;
      logic [CAP_W-1:0] cap;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         cap = '0;
      end else if (pick < 3) begin
         cap = CAP_W'($urandom_range(DEPTH + 1, 127));
      end else if (pick < 6) begin
         cap = CAP_W'(DEPTH);
      end else begin
         cap = CAP_W'($urandom_range(1, 12));
      end
      write_capacity(cap);
      if ($urandom_range(0, 2) == 0) begin
         alpha_size = 256;
      end else begin
         alpha_size = $urandom_range(2, 6);
         alpha_base = 8'($urandom_range(0, 255));
      end
      // Now and then the old contents are kept, so the new capacity may sit below the count.
      if ($urandom_range(0, 7) != 0) begin
         issue(OP_RESTART, pick_char(), 1'b0, '0);
      end
      guard = 0;
      while (!session_closed && guard < 150) begin
         if ($urandom_range(0, 11) == 0) begin
            issue(op_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0, '0);
         end else begin
            issue(OP_INSERT, pick_char(), 1'b0, '0);
         end
         guard++;
      end
      repeat ($urandom_range(0, 2)) issue(OP_INSERT, pick_char(), 1'b0, '0);
      n_pops = $urandom_range(0, fill + 2);
      repeat (n_pops) begin
         if ($urandom_range(0, 9) == 0) begin
            issue(OP_INSERT, pick_char(), 1'b0, '0);
         end else begin
            issue($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, pick_char(), 1'b0, '0);
         end
      end
   endtask

   // Result checker.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with none expected: status %0d char %0h count %0d",
                     $realtime, rsp_data.status, rsp_data.char_out, rsp_data.fill_count);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $realtime, want.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.char_out !== want.char_out) begin
               $display("%0t: char_out expected %0h actual %0h",
                        $realtime, want.char_out, rsp_data.char_out);
               errors++;
            end
            if (rsp_data.fill_count !== want.fill_count) begin
               $display("%0t: fill_count expected %0d actual %0d",
                        $realtime, want.fill_count, rsp_data.fill_count);
               errors++;
            end
         end
      end
   end

   // Receiver back-pressure, in one of four randomly chosen patterns.
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 48 == 0) begin
         stall_mode <= $urandom_range(0, 3);
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (stall_cycle % 3 != 0);
      endcase
   end

   initial begin
      foreach (deque_store[i]) deque_store[i] = '0;

      item_row(OP_POP_FRONT, 8'h00, 1'b1, ST_EMPTY,    8'h00, 0);
      item_row(OP_POP_BACK,  8'hFF, 1'b1, ST_EMPTY,    8'h00, 0);
      item_row(OP_INSERT,    8'h00, 1'b1, ST_INSERTED, 8'h00, 1);
      item_row(OP_INSERT,    8'hFF, 1'b0, ST_INSERTED, 8'h00, 0);
      item_row(OP_INSERT,    8'h41, 1'b0, ST_INSERTED, 8'h00, 0);
      item_row(OP_INSERT,    8'hFF, 1'b0, ST_INSERTED, 8'h00, 0);
      // Front insert equal to the back character ends the session.
      item_row(OP_INSERT,    8'hFF, 1'b1, ST_MATCH,    8'hFF, 4);
      item_row(OP_INSERT,    8'h12, 1'b1, ST_REJECTED, 8'h00, 4);
      item_row(OP_POP_FRONT, 8'h00, 1'b0, ST_POPPED,   8'h00, 0);
      item_row(OP_POP_BACK,  8'h00, 1'b0, ST_POPPED,   8'h00, 0);
      // Pops do not reopen an ended session.
      item_row(OP_INSERT,    8'h7E, 1'b1, ST_REJECTED, 8'h00, 2);
      item_row(OP_RESTART,   8'hA5, 1'b1, ST_CLEARED,  8'h00, 0);
      cfg_row(7'd1);
      item_row(OP_INSERT,    8'h80, 1'b1, ST_FULL,     8'h00, 1);
      item_row(OP_INSERT,    8'h01, 1'b1, ST_REJECTED, 8'h00, 1);
      item_row(OP_POP_BACK,  8'h00, 1'b0, ST_POPPED,   8'h00, 0);
      cfg_row(7'd0);
      item_row(OP_RESTART,   8'h00, 1'b1, ST_CLEARED,  8'h00, 0);
      item_row(OP_INSERT,    8'h55, 1'b1, ST_REJECTED, 8'h00, 0);
      item_row(OP_POP_FRONT, 8'h00, 1'b1, ST_EMPTY,    8'h00, 0);
      cfg_row(7'd127);
      item_row(OP_RESTART,   8'hFF, 1'b1, ST_CLEARED,  8'h00, 0);
      item_row(OP_INSERT,    8'h01, 1'b0, ST_INSERTED, 8'h00, 0);
      item_row(OP_INSERT,    8'h02, 1'b0, ST_INSERTED, 8'h00, 0);
      item_row(OP_INSERT,    8'h03, 1'b0, ST_INSERTED, 8'h00, 0);
      // Capacity lowered below the held count: the next insert is refused.
      cfg_row(7'd2);
      item_row(OP_INSERT,    8'h04, 1'b1, ST_REJECTED, 8'h00, 3);
      item_row(OP_POP_FRONT, 8'h00, 1'b0, ST_POPPED,   8'h00, 0);
      item_row(OP_POP_BACK,  8'h00, 1'b0, ST_POPPED,   8'h00, 0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CFG) begin
            write_capacity(directed_rows[i].cap);
         end else begin
            issue(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].typed,
                  directed_rows[i].want);
         end
      end

      while (sent_items < 1700) run_session();

      drain();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/aecd_pkg.sv
rtl/aecd_cell.sv
rtl/alternating_end_char_deque_core.sv
rtl/aecd_checker.sv
tb/alternating_end_char_deque_core_tb.sv
